### hdl/vrot_pkg.sv
package vrot_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_LEN          = 24;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 17;
  localparam int unsigned VW     = 48;
  localparam int unsigned ZW     = 33;
  localparam int unsigned PW     = 48;
  localparam int unsigned FRAC   = 30;
  localparam int unsigned ANG_SH = 16;

  localparam logic signed [36:0] ANG_SCALE = 37'sd44798133901;
  localparam logic signed [30:0] INV_GAIN  = 31'sd652032874;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 17'sd46341;

  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef struct packed {
    logic signed [VW-1:0] set_x;
    logic signed [VW-1:0] set_y;
    logic signed [VW-1:0] meas_x;
    logic signed [VW-1:0] meas_y;
    logic signed [ZW-1:0] z;
  } vrot_data_t;

endpackage

### hdl/vrot_prep.sv
module vrot_prep import vrot_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] set_vel_x_i,
  input  logic signed [IN_W-1:0] set_vel_y_i,
  input  logic signed [IN_W-1:0] meas_vel_x_i,
  input  logic signed [IN_W-1:0] meas_vel_y_i,
  input  logic signed [IN_W-1:0] heading_mrad_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vrot_data_t             out_data_o
);

  logic                 a_valid_q;
  logic                 a_ready;
  logic [PW-1:0]        prod_q;
  logic signed [PW-1:0] ang_prod;
  logic signed [VW-1:0] sx_q, sy_q, mx_q, my_q;
  logic signed [VW-1:0] sx_d, sy_d, mx_d, my_d;

  logic                 b_valid_q;
  logic                 b_ready;
  vrot_data_t           data_q, data_d;
  logic [PW-1:0]        rnd_sum;
  logic [31:0]          phase;
  logic [31:0]          theta;
  logic [31:0]          theta_f;
  logic                 fold;

  // The heading is scaled to a binary angle where a full turn is 2^32.
  assign ang_prod = PW'(heading_mrad_i) * PW'(ANG_SCALE);
  assign sx_d     = VW'(set_vel_x_i)  * VW'(INV_GAIN);
  assign sy_d     = VW'(set_vel_y_i)  * VW'(INV_GAIN);
  assign mx_d     = VW'(meas_vel_x_i) * VW'(INV_GAIN);
  assign my_d     = VW'(meas_vel_y_i) * VW'(INV_GAIN);

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      prod_q <= ang_prod;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      mx_q   <= mx_d;
      my_q   <= my_d;
    end
  end

  // Rounded phase, rotation by minus the heading, then a fold into the
  // half turn around zero so that the CORDIC chain converges.
  always_comb begin
    rnd_sum = prod_q + PW'(32768);
    phase   = rnd_sum[ANG_SH+31:ANG_SH];
    theta   = 32'd0 - phase;
    fold    = theta[31] ^ theta[30];
    theta_f = {theta[31] ^ fold, theta[30:0]};
    data_d.z = $signed({theta_f[31], theta_f});
    if (fold) begin
      data_d.set_x  = -sx_q;
      data_d.set_y  = -sy_q;
      data_d.meas_x = -mx_q;
      data_d.meas_y = -my_q;
    end else begin
      data_d.set_x  = sx_q;
      data_d.set_y  = sy_q;
      data_d.meas_x = mx_q;
      data_d.meas_y = my_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = data_q;

endmodule

### hdl/vrot_cell.sv
module vrot_cell import vrot_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  vrot_data_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output vrot_data_t out_data_o
);

  localparam logic signed [ZW-1:0] Atan = ZW'(ATAN_TAB[SHIFT]);

  logic       valid_q;
  vrot_data_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // Both vectors turn in the same direction, steered by the shared angle.
  always_comb begin
    if (!in_data_i.z[ZW-1]) begin
      data_d.set_x  = in_data_i.set_x  - (in_data_i.set_y  >>> SHIFT);
      data_d.set_y  = in_data_i.set_y  + (in_data_i.set_x  >>> SHIFT);
      data_d.meas_x = in_data_i.meas_x - (in_data_i.meas_y >>> SHIFT);
      data_d.meas_y = in_data_i.meas_y + (in_data_i.meas_x >>> SHIFT);
      data_d.z      = in_data_i.z - Atan;
    end else begin
      data_d.set_x  = in_data_i.set_x  + (in_data_i.set_y  >>> SHIFT);
      data_d.set_y  = in_data_i.set_y  - (in_data_i.set_x  >>> SHIFT);
      data_d.meas_x = in_data_i.meas_x + (in_data_i.meas_y >>> SHIFT);
      data_d.meas_y = in_data_i.meas_y - (in_data_i.meas_x >>> SHIFT);
      data_d.z      = in_data_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hdl/vrot_post.sv
module vrot_post import vrot_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  vrot_data_t              in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] rot_set_x_o,
  output logic signed [OUT_W-1:0] rot_set_y_o,
  output logic signed [OUT_W-1:0] rot_meas_x_o,
  output logic signed [OUT_W-1:0] rot_meas_y_o
);

  localparam int unsigned RW = VW + 1 - FRAC;

  logic                    valid_q;
  logic signed [OUT_W-1:0] sx_q, sy_q, mx_q, my_q;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [VW-1:0] v);
    logic signed [VW:0]   sum;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] lim;
    sum = {v[VW-1], v} + (VW+1)'(1 << (FRAC - 1));
    r   = sum[VW:FRAC];
    lim = RW'(OUT_LIMIT);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r[OUT_W-1:0];
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sx_q <= finish(in_data_i.set_x);
      sy_q <= finish(in_data_i.set_y);
      mx_q <= finish(in_data_i.meas_x);
      my_q <= finish(in_data_i.meas_y);
    end
  end

  assign out_valid_o  = valid_q;
  assign rot_set_x_o  = sx_q;
  assign rot_set_y_o  = sy_q;
  assign rot_meas_x_o = mx_q;
  assign rot_meas_y_o = my_q;

endmodule

### hdl/velocity_frame_rotator.sv
// Channel | Handshake                | Beat contents
// in      | in_valid_i / in_ready_o  | set_vel_x/y, meas_vel_x/y, heading_mrad
// out     | out_valid_o / out_ready_i| rot_set_x/y, rot_meas_x/y
//
// One beat is accepted per cycle unless a stalled output has filled the
// pipeline; a beat passes through the scaling register, the quadrant fold
// register, the register in each CORDIC cell, and the rounding and clamping register.
// Every stage has its own valid bit and holds under a stall, so empty stages
// keep filling while a finished beat waits at the output.
// Reset clears only the valid bits.
module velocity_frame_rotator import vrot_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  set_vel_x_i,
  input  logic signed [IN_W-1:0]  set_vel_y_i,
  input  logic signed [IN_W-1:0]  meas_vel_x_i,
  input  logic signed [IN_W-1:0]  meas_vel_y_i,
  input  logic signed [IN_W-1:0]  heading_mrad_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] rot_set_x_o,
  output logic signed [OUT_W-1:0] rot_set_y_o,
  output logic signed [OUT_W-1:0] rot_meas_x_o,
  output logic signed [OUT_W-1:0] rot_meas_y_o
);

  localparam int unsigned N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  logic       chain_valid [N+1];
  logic       chain_ready [N+1];
  vrot_data_t chain_data  [N+1];

  vrot_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .set_vel_x_i    (set_vel_x_i),
    .set_vel_y_i    (set_vel_y_i),
    .meas_vel_x_i   (meas_vel_x_i),
    .meas_vel_y_i   (meas_vel_y_i),
    .heading_mrad_i (heading_mrad_i),
    .out_valid_o    (chain_valid[0]),
    .out_ready_i    (chain_ready[0]),
    .out_data_o     (chain_data[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    vrot_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  vrot_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (chain_valid[N]),
    .in_ready_o   (chain_ready[N]),
    .in_data_i    (chain_data[N]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rot_set_x_o  (rot_set_x_o),
    .rot_set_y_o  (rot_set_y_o),
    .rot_meas_x_o (rot_meas_x_o),
    .rot_meas_y_o (rot_meas_y_o)
  );

endmodule

### hdl/vrot_checker.sv
module vrot_checker import vrot_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic signed [IN_W-1:0]  set_vel_x_i,
  input logic signed [IN_W-1:0]  set_vel_y_i,
  input logic signed [IN_W-1:0]  meas_vel_x_i,
  input logic signed [IN_W-1:0]  meas_vel_y_i,
  input logic signed [IN_W-1:0]  heading_mrad_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] rot_set_x_o,
  input logic signed [OUT_W-1:0] rot_set_y_o,
  input logic signed [OUT_W-1:0] rot_meas_x_o,
  input logic signed [OUT_W-1:0] rot_meas_y_o
);

  // A waiting input beat stays put until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(set_vel_x_i) &&
      $stable(set_vel_y_i) && $stable(meas_vel_x_i) && $stable(meas_vel_y_i) &&
      $stable(heading_mrad_i))
    else $error("input beat changed while stalled");

  // A waiting output beat stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rot_set_x_o) &&
      $stable(rot_set_y_o) && $stable(rot_meas_x_o) && $stable(rot_meas_y_o))
    else $error("output beat changed while stalled");

  // Input back-pressure only ever comes from a stalled output beat.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

  // Every delivered component lies within the clamp limits.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      rot_set_x_o  <= OUT_LIMIT && rot_set_x_o  >= -OUT_LIMIT &&
      rot_set_y_o  <= OUT_LIMIT && rot_set_y_o  >= -OUT_LIMIT &&
      rot_meas_x_o <= OUT_LIMIT && rot_meas_x_o >= -OUT_LIMIT &&
      rot_meas_y_o <= OUT_LIMIT && rot_meas_y_o >= -OUT_LIMIT)
    else $error("output component outside clamp range");

endmodule

bind velocity_frame_rotator vrot_checker u_vrot_checker (.*);
